FILE: src/obdpve_pkg.sv
// obdpve_pkg: shared constants, codes, stage types and scaling tables
// for the OBD-II PID value encoder; no dependencies
package obdpve_pkg;

    // fixed-point format of the physical value
    localparam int FRAC_BITS = 16;
    localparam int VALUE_W   = 40;

    // clamped scaled input: 0 .. 2^(FRAC_BITS+17), anything above saturates every PID
    localparam int XC_W   = FRAC_BITS + 18;
    localparam int X_W    = (VALUE_W + 1 > XC_W + 1) ? VALUE_W + 1 : XC_W + 1;
    localparam int MUL_W  = 16;
    localparam int OFF_W  = 7;
    localparam int PROD_W = XC_W + MUL_W;
    localparam int T_W    = PROD_W + 1;
    localparam int P_W    = T_W - FRAC_BITS;

    // integer quotient stage: reciprocal multiply for the divide by 3 or 100
    localparam int PC_W      = 23;
    localparam int REC_SHIFT = 30;
    localparam int REC_W     = 29;
    localparam int RP_W      = PC_W + REC_W;
    localparam int Q_W       = RP_W - REC_SHIFT;

    localparam logic [REC_W-1:0] RECIP_3   = REC_W'(357913942);
    localparam logic [REC_W-1:0] RECIP_100 = REC_W'(10737419);

    // response size codes
    localparam logic [1:0] SZ_NONE = 2'd0;
    localparam logic [1:0] SZ_ONE  = 2'd1;
    localparam logic [1:0] SZ_TWO  = 2'd2;
    localparam logic [1:0] SZ_O2   = 2'd3;

    // divisor codes
    localparam logic [1:0] DV_1   = 2'd0;
    localparam logic [1:0] DV_3   = 2'd1;
    localparam logic [1:0] DV_100 = 2'd2;

    // byte counts
    localparam logic [1:0] BC_ZERO = 2'd0;
    localparam logic [1:0] BC_ONE  = 2'd1;
    localparam logic [1:0] BC_TWO  = 2'd2;

    // PID codes
    localparam logic [7:0] PID_LOAD         = 8'h04;
    localparam logic [7:0] PID_COOLANT      = 8'h05;
    localparam logic [7:0] PID_STFT_B1      = 8'h06;
    localparam logic [7:0] PID_LTFT_B1      = 8'h07;
    localparam logic [7:0] PID_FUEL_PRESS   = 8'h0A;
    localparam logic [7:0] PID_MAP          = 8'h0B;
    localparam logic [7:0] PID_RPM          = 8'h0C;
    localparam logic [7:0] PID_SPEED        = 8'h0D;
    localparam logic [7:0] PID_TIMING       = 8'h0E;
    localparam logic [7:0] PID_INTAKE_TEMP  = 8'h0F;
    localparam logic [7:0] PID_MAF          = 8'h10;
    localparam logic [7:0] PID_THROTTLE     = 8'h11;
    localparam logic [7:0] PID_O2_S1        = 8'h14;
    localparam logic [7:0] PID_O2_S2        = 8'h15;
    localparam logic [7:0] PID_RUN_TIME     = 8'h1F;
    localparam logic [7:0] PID_MIL_DIST     = 8'h21;
    localparam logic [7:0] PID_EVAP_PURGE   = 8'h2E;
    localparam logic [7:0] PID_FUEL_LEVEL   = 8'h2F;
    localparam logic [7:0] PID_BARO         = 8'h33;
    localparam logic [7:0] PID_CTRL_VOLT    = 8'h42;
    localparam logic [7:0] PID_ABS_LOAD     = 8'h43;
    localparam logic [7:0] PID_LAMBDA_CMD   = 8'h44;
    localparam logic [7:0] PID_REL_THROTTLE = 8'h45;
    localparam logic [7:0] PID_AMBIENT      = 8'h46;
    localparam logic [7:0] PID_PEDAL_D      = 8'h49;
    localparam logic [7:0] PID_CMD_THROTTLE = 8'h4C;
    localparam logic [7:0] PID_OIL_TEMP     = 8'h5C;
    localparam logic [7:0] PID_FUEL_RATE    = 8'h5E;

    typedef struct packed {
        logic [1:0]       size;
        logic [1:0]       dv;
        logic [OFF_W-1:0] off;
        logic [MUL_W-1:0] mul;
    } t_scale;

    // stage 1 -> 2: clamped offset value and factors
    typedef struct packed {
        logic [1:0]       size;
        logic [1:0]       dv;
        logic [MUL_W-1:0] mul;
        logic [XC_W-1:0]  xc;
    } t_s1;

    // stage 3 -> 4: pre-divide integer and saturation flag
    typedef struct packed {
        logic [1:0]      size;
        logic [1:0]      dv;
        logic            sat;
        logic [PC_W-1:0] pc;
    } t_s3;

    // inverse scaling per PID
    function automatic t_scale scale_of(input logic [7:0] pid);
        t_scale s;
        s.size = SZ_NONE;
        s.dv   = DV_1;
        s.off  = '0;
        s.mul  = MUL_W'(1);
        unique case (pid) inside
            PID_LOAD, PID_THROTTLE, PID_EVAP_PURGE, PID_FUEL_LEVEL,
            PID_REL_THROTTLE, PID_PEDAL_D, PID_CMD_THROTTLE: begin
                s.size = SZ_ONE; s.mul = MUL_W'(255); s.dv = DV_100;
            end
            PID_COOLANT, PID_INTAKE_TEMP, PID_AMBIENT, PID_OIL_TEMP: begin
                s.size = SZ_ONE; s.off = OFF_W'(40);
            end
            PID_STFT_B1, PID_LTFT_B1: begin
                s.size = SZ_ONE; s.off = OFF_W'(100); s.mul = MUL_W'(128); s.dv = DV_100;
            end
            PID_FUEL_PRESS: begin
                s.size = SZ_ONE; s.dv = DV_3;
            end
            PID_MAP, PID_SPEED, PID_BARO: begin
                s.size = SZ_ONE;
            end
            PID_RPM: begin
                s.size = SZ_TWO; s.mul = MUL_W'(4);
            end
            PID_TIMING: begin
                s.size = SZ_ONE; s.off = OFF_W'(64); s.mul = MUL_W'(2);
            end
            PID_MAF: begin
                s.size = SZ_TWO; s.mul = MUL_W'(100);
            end
            PID_O2_S1, PID_O2_S2: begin
                s.size = SZ_O2; s.mul = MUL_W'(200);
            end
            PID_RUN_TIME, PID_MIL_DIST: begin
                s.size = SZ_TWO;
            end
            PID_CTRL_VOLT: begin
                s.size = SZ_TWO; s.mul = MUL_W'(1000);
            end
            PID_ABS_LOAD: begin
                s.size = SZ_TWO; s.mul = MUL_W'(255); s.dv = DV_100;
            end
            PID_LAMBDA_CMD: begin
                s.size = SZ_TWO; s.mul = MUL_W'(32768);
            end
            PID_FUEL_RATE: begin
                s.size = SZ_TWO; s.mul = MUL_W'(20);
            end
            default: begin
                s.size = SZ_NONE;
            end
        endcase
        return s;
    endfunction

    // rounding term: half the full denominator dv * 2^FRAC_BITS
    function automatic logic [T_W-1:0] half_of(input logic [1:0] dv);
        logic [T_W-1:0] h;
        unique case (dv)
            DV_3:    h = T_W'(3) << (FRAC_BITS - 1);
            DV_100:  h = T_W'(100) << (FRAC_BITS - 1);
            default: h = T_W'(1) << (FRAC_BITS - 1);
        endcase
        return h;
    endfunction

    // reciprocal of the divisor scaled by 2^REC_SHIFT, rounded up
    function automatic logic [REC_W-1:0] recip_of(input logic [1:0] dv);
        logic [REC_W-1:0] r;
        unique case (dv)
            DV_3:    r = RECIP_3;
            DV_100:  r = RECIP_100;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/obdpve_if.sv
// obdpve_in_if / obdpve_out_if: valid-ready channels of the PID value encoder
// depends on obdpve_pkg for the value width
interface obdpve_in_if import obdpve_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [7:0]         pid;
    logic [VALUE_W-1:0] value;

    modport source (output valid, pid, value, input ready);
    modport sink   (input valid, pid, value, output ready);
endinterface

interface obdpve_out_if ();
    logic       valid;
    logic       ready;
    logic       supported;
    logic [1:0] byte_count;
    logic [7:0] data_a;
    logic [7:0] data_b;

    modport source (output valid, supported, byte_count, data_a, data_b, input ready);
    modport sink   (input valid, supported, byte_count, data_a, data_b, output ready);
endinterface

FILE: src/obdpve_front.sv
// obdpve_front: PID decode, offset add and input clamp (pipeline stage 1)
// depends on obdpve_pkg
module obdpve_front import obdpve_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_pid,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output t_s1                o_s1
);

    t_scale         scl;
    logic [X_W-1:0] x;
    logic           x_neg;
    logic           x_big;
    t_s1            n_s1;
    t_s1            r_s1;
    logic           r_v;

    // value plus offset, both in the input fixed-point format
    always_comb begin
        scl   = scale_of(i_pid);
        x     = {{(X_W-VALUE_W){i_value[VALUE_W-1]}}, i_value}
              + (X_W'(scl.off) << FRAC_BITS);
        x_neg = x[X_W-1];
        x_big = |x[X_W-2:XC_W-1];
    end

    // negatives always clamp to zero, large values always saturate
    always_comb begin
        n_s1.size = scl.size;
        n_s1.dv   = scl.dv;
        n_s1.mul  = scl.mul;
        if (x_neg) begin
            n_s1.xc = '0;
        end else if (x_big) begin
            n_s1.xc = XC_W'(1) << (XC_W - 1);
        end else begin
            n_s1.xc = x[XC_W-1:0];
        end
    end

    assign o_ready = !r_v || i_ready;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_v;
    assign o_s1    = r_s1;

endmodule

FILE: src/obdpve_scale.sv
// obdpve_scale: constant multiply and rounding add with pre-divide clamp
// (pipeline stages 2 and 3); depends on obdpve_pkg
module obdpve_scale import obdpve_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s1  i_s1,
    output logic o_valid,
    input  logic i_ready,
    output t_s3  o_s3
);

    logic              r_v2;
    logic [1:0]        r_size2;
    logic [1:0]        r_dv2;
    logic [PROD_W-1:0] r_prod2;
    logic              rdy2;

    logic              r_v3;
    t_s3               r_s3;
    t_s3               n_s3;
    logic              rdy3;
    logic [T_W-1:0]    t;
    logic [P_W-1:0]    p;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = rdy2;

    // stage 2: value times the PID multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r_size2 <= i_s1.size;
            r_dv2   <= i_s1.dv;
            r_prod2 <= PROD_W'(i_s1.xc) * PROD_W'(i_s1.mul);
        end
    end

    // stage 3: add half the denominator, drop fraction bits, flag overflow
    always_comb begin
        t          = {1'b0, r_prod2} + half_of(r_dv2);
        p          = t[T_W-1:FRAC_BITS];
        n_s3.size  = r_size2;
        n_s3.dv    = r_dv2;
        n_s3.sat   = |p[P_W-1:PC_W];
        n_s3.pc    = p[PC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_s3    = r_s3;

endmodule

FILE: src/obdpve_back.sv
// obdpve_back: reciprocal divide, saturation and byte packing
// (pipeline stages 4 and 5, stage 5 is the output register); depends on obdpve_pkg
module obdpve_back import obdpve_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_s3        i_s3,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_supported,
    output logic [1:0] o_byte_count,
    output logic [7:0] o_data_a,
    output logic [7:0] o_data_b
);

    logic            r_v4;
    t_s3             r_s4;
    logic [RP_W-1:0] r_rec4;
    logic            rdy4;

    logic            r_v5;
    logic            rdy5;
    logic [PC_W-1:0] q;
    logic [15:0]     maxv;
    logic [15:0]     res;
    logic            n_supported;
    logic [1:0]      n_byte_count;
    logic [7:0]      n_data_a;
    logic [7:0]      n_data_b;
    logic            r_supported;
    logic [1:0]      r_byte_count;
    logic [7:0]      r_data_a;
    logic [7:0]      r_data_b;

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign o_ready = rdy4;

    // stage 4: multiply by the scaled reciprocal of the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && i_valid) begin
            r_s4   <= i_s3;
            r_rec4 <= RP_W'(i_s3.pc) * RP_W'(recip_of(i_s3.dv));
        end
    end

    // stage 5: quotient, clamp to the response range, pack bytes
    always_comb begin
        if (r_s4.dv == DV_1) begin
            q = r_s4.pc;
        end else begin
            q = PC_W'(r_rec4[RP_W-1:REC_SHIFT]);
        end
        maxv = (r_s4.size == SZ_TWO) ? 16'hFFFF : 16'h00FF;
        if (r_s4.sat || q > PC_W'(maxv)) begin
            res = maxv;
        end else begin
            res = q[15:0];
        end
        case (r_s4.size)
            SZ_ONE: begin
                n_supported  = 1'b1;
                n_byte_count = BC_ONE;
                n_data_a     = res[7:0];
                n_data_b     = 8'h00;
            end
            SZ_TWO: begin
                n_supported  = 1'b1;
                n_byte_count = BC_TWO;
                n_data_a     = res[15:8];
                n_data_b     = res[7:0];
            end
            SZ_O2: begin
                n_supported  = 1'b1;
                n_byte_count = BC_TWO;
                n_data_a     = res[7:0];
                n_data_b     = 8'hFF;
            end
            default: begin
                n_supported  = 1'b0;
                n_byte_count = BC_ZERO;
                n_data_a     = 8'h00;
                n_data_b     = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (rdy5) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5 && r_v4) begin
            r_supported  <= n_supported;
            r_byte_count <= n_byte_count;
            r_data_a     <= n_data_a;
            r_data_b     <= n_data_b;
        end
    end

    assign o_valid      = r_v5;
    assign o_supported  = r_supported;
    assign o_byte_count = r_byte_count;
    assign o_data_a     = r_data_a;
    assign o_data_b     = r_data_b;

endmodule

FILE: src/obd_pid_value_encoder.sv
// OBD-II PID value encoder: takes a PID and a signed Q24.16 physical value and
// returns the J1979 response data bytes, rounded half up and saturated. The
// block is a five-stage pipeline (decode and offset, constant multiply,
// rounding add, reciprocal divide, clamp and pack) that takes one item per
// cycle unless the output stalls. Each stage holds its item while the next
// one is full and stalled, so a stall on the output fills empty stages before
// the input stops taking items.
// Depends on obdpve_pkg, obdpve_if, obdpve_front, obdpve_scale, obdpve_back.
module obd_pid_value_encoder import obdpve_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obdpve_in_if.sink   i_req,
    obdpve_out_if.source o_rsp
);

    logic f_valid;
    logic f_ready;
    t_s1  f_s1;
    logic s_valid;
    logic s_ready;
    t_s3  s_s3;

    // decode, offset and clamp
    obdpve_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_pid   (i_req.pid),
        .i_value (i_req.value),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_s1    (f_s1)
    );

    // multiply and round
    obdpve_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_s1    (f_s1),
        .o_valid (s_valid),
        .i_ready (s_ready),
        .o_s3    (s_s3)
    );

    // divide, saturate and pack
    obdpve_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_valid),
        .o_ready      (s_ready),
        .i_s3         (s_s3),
        .o_valid      (o_rsp.valid),
        .i_ready      (o_rsp.ready),
        .o_supported  (o_rsp.supported),
        .o_byte_count (o_rsp.byte_count),
        .o_data_a     (o_rsp.data_a),
        .o_data_b     (o_rsp.data_b)
    );

endmodule

FILE: src/obdpve_chk.sv
// obdpve_chk: port-level checks of the PID value encoder, bound to the top level
// depends on obdpve_pkg for the byte count codes
module obdpve_chk import obdpve_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_supported,
    input logic [1:0] i_byte_count,
    input logic [7:0] i_data_a,
    input logic [7:0] i_data_b
);

    // output channel is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_supported) && $stable(i_byte_count)
            && $stable(i_data_a) && $stable(i_data_b))
        else $error("stalled result changed");

    // unsupported PID sends no data
    a_unsup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_supported |->
            i_byte_count == BC_ZERO && i_data_a == 8'h00 && i_data_b == 8'h00)
        else $error("unsupported PID with data");

    // supported PID sends one or two bytes
    a_sup_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_supported |->
            i_byte_count == BC_ONE || i_byte_count == BC_TWO)
        else $error("supported PID with bad byte count");

    // one-byte responses leave the second byte clear
    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_byte_count == BC_ONE |-> i_data_b == 8'h00)
        else $error("one-byte response with second byte set");

endmodule

bind obd_pid_value_encoder obdpve_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_supported  (o_rsp.supported),
    .i_byte_count (o_rsp.byte_count),
    .i_data_a     (o_rsp.data_a),
    .i_data_b     (o_rsp.data_b)
);
